// ===== sv/rlbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbe_pkg
// Shared constants, types and the run flush function of the run-length
// byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbe_pkg;

  localparam int LEN_W            = 17;
  localparam int MAX_BLOCK_LENGTH = 65536;
  localparam int RES_SLOTS        = 4;
  localparam int CNT_W            = $clog2(RES_SLOTS + 1);
  localparam int PTR_W            = $clog2(RES_SLOTS);

  localparam logic [LEN_W-1:0] MAX_LEN          = LEN_W'(MAX_BLOCK_LENGTH);
  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = LEN_W'(4096);

  localparam logic [7:0] ESC_MARK  = 8'hFF;
  localparam logic [7:0] RUN_CAP   = 8'd255;
  localparam logic [7:0] SHORT_RUN = 8'd3;

  typedef logic [7:0] byte_t;

  // Encoded bytes of one closed run: up to three bytes.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } flush_t;

  function automatic flush_t flush_run(input byte_t value, input byte_t length);
    flush_t f;
    f.cnt   = '0;
    f.bytes = '0;
    if (length > SHORT_RUN) begin
      f.cnt      = 2'd3;
      f.bytes[0] = ESC_MARK;
      f.bytes[1] = length;
      f.bytes[2] = value;
    end else if (length != '0) begin
      f.cnt      = length[1:0];
      f.bytes[0] = value;
      f.bytes[1] = value;
      f.bytes[2] = value;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/run_length_byte_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// run_length_byte_encoder_unit
// Run-length byte encoder with a 0xFF escape marker, one input byte per item.
// ----------------------------------------------------------------------------
//  Channel | Ports                                       | Handshake
//  --------+---------------------------------------------+------------------
//  input   | in_byte                                     | in_valid/in_ready
//  result  | out_byte, out_valid, out_last, out_total    | out_item_valid/
//          |                                             | out_item_ready
//  config  | cfg_wr_data (block_length)                  | cfg_wr_en
//
//  An item is encoded in the cycle it is accepted and its results land in a
//  four-entry result register, drained one result per cycle while
//  out_item_ready is high. An item with results holds in_ready low while the
//  result register drains, until its last result is being taken.
//  in_ready is high when the result register is empty or its last entry is
//  taken in the same cycle. Reset (rst_n low, synchronous) clears all block
//  state and loads block_length with 4096; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_byte_encoder_unit
  import rlbe_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_wr_en,
  input  wire [LEN_W-1:0]  cfg_wr_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [7:0]        in_byte,
  output logic             out_item_valid,
  input  wire              out_item_ready,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_last,
  output logic [LEN_W-1:0] out_total
);

  logic [LEN_W-1:0] block_len_r;
  byte_t            run_val_r, run_val_nxt;
  byte_t            run_len_r, run_len_nxt;
  logic [LEN_W-1:0] taken_r, taken_nxt;
  logic [LEN_W-1:0] emitted_r, emitted_nxt;
  logic             full_r, full_nxt;

  logic [RES_SLOTS-1:0][7:0] res_r, res_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [PTR_W-1:0]          ptr_r;
  logic                      res_valid_r, res_valid_nxt;
  logic                      blk_last_r;
  logic [LEN_W-1:0]          total_r, total_nxt;

  logic             in_acc, out_acc;
  logic [LEN_W-1:0] eff_len;
  logic             last;
  logic             extend;
  flush_t           flush_a, flush_b;
  logic [LEN_W:0]   emit_a, emit_all;
  logic             start_ok;
  byte_t            val1, len1;
  logic             full1;
  logic [CNT_W-1:0] n_tot;

  assign out_item_valid = (cnt_r != '0);
  assign out_acc        = out_item_valid && out_item_ready;
  assign in_ready       = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_item_ready);
  assign in_acc         = in_valid && in_ready;

  always_comb begin
    if (block_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (block_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = block_len_r;
    end
  end

  assign last   = ({1'b0, taken_r} + (LEN_W+1)'(1)) >= {1'b0, eff_len};
  assign extend = (run_len_r != '0) && (in_byte == run_val_r) && (run_len_r < RUN_CAP);

  // First phase: extend the open run, or close it and try to open a new one.
  always_comb begin
    flush_a  = '0;
    val1     = run_val_r;
    len1     = run_len_r;
    full1    = full_r;
    if (!full_r && !extend) begin
      flush_a = flush_run(run_val_r, run_len_r);
    end
    emit_a   = {1'b0, emitted_r} + (LEN_W+1)'(flush_a.cnt);
    start_ok = emit_a < ({1'b0, eff_len} - (LEN_W+1)'(1));
    if (!full_r) begin
      if (extend) begin
        len1 = run_len_r + 8'd1;
      end else if (start_ok) begin
        val1 = in_byte;
        len1 = 8'd1;
      end else begin
        len1  = '0;
        full1 = 1'b1;
      end
    end
  end

  // Second phase: the final byte of the block closes whatever run is open.
  always_comb begin
    flush_b  = last ? flush_run(val1, len1) : '0;
    emit_all = emit_a + (LEN_W+1)'(flush_b.cnt);
    n_tot    = CNT_W'(flush_a.cnt) + CNT_W'(flush_b.cnt);
  end

  always_comb begin
    case (flush_a.cnt)
      2'd0: res_nxt = {8'h00, flush_b.bytes[2], flush_b.bytes[1], flush_b.bytes[0]};
      2'd1: res_nxt = {flush_b.bytes[2], flush_b.bytes[1], flush_b.bytes[0],
                       flush_a.bytes[0]};
      2'd2: res_nxt = {flush_b.bytes[1], flush_b.bytes[0], flush_a.bytes[1],
                       flush_a.bytes[0]};
      default: res_nxt = {flush_b.bytes[0], flush_a.bytes[2], flush_a.bytes[1],
                          flush_a.bytes[0]};
    endcase
  end

  always_comb begin
    run_val_nxt   = val1;
    run_len_nxt   = len1;
    full_nxt      = full1;
    taken_nxt     = taken_r + LEN_W'(1);
    emitted_nxt   = emit_all[LEN_W-1:0];
    total_nxt     = emit_all[LEN_W-1:0];
    cnt_nxt       = n_tot;
    res_valid_nxt = 1'b1;
    if (last) begin
      run_val_nxt = '0;
      run_len_nxt = '0;
      full_nxt    = 1'b0;
      taken_nxt   = '0;
      emitted_nxt = '0;
      // A final byte that encodes nothing still reports the block end.
      if (n_tot == '0) begin
        cnt_nxt       = CNT_W'(1);
        res_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= BLOCK_LENGTH_RST;
    end else if (cfg_wr_en) begin
      block_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r <= '0;
      run_len_r <= '0;
      taken_r   <= '0;
      emitted_r <= '0;
      full_r    <= 1'b0;
    end else if (in_acc) begin
      run_val_r <= run_val_nxt;
      run_len_r <= run_len_nxt;
      taken_r   <= taken_nxt;
      emitted_r <= emitted_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
      ptr_r <= '0;
    end else if (out_acc) begin
      cnt_r <= cnt_r - CNT_W'(1);
      ptr_r <= ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r       <= res_nxt;
      res_valid_r <= res_valid_nxt;
      blk_last_r  <= last;
      total_r     <= total_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_byte  = res_valid_r ? res_r[ptr_r] : 8'h00;
  assign out_last  = blk_last_r && (cnt_r == CNT_W'(1));
  assign out_total = out_last ? total_r : '0;

endmodule

`default_nettype wire

// ===== sv/rlbe_checker.sv =====
// ----------------------------------------------------------------------------
// rlbe_checker
// Port-level checks on the run-length byte encoder, bound to the encoder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbe_checker
  import rlbe_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_item_valid,
  input wire              out_item_ready,
  input wire [7:0]        out_byte,
  input wire              out_valid,
  input wire              out_last,
  input wire [LEN_W-1:0]  out_total
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_item_ready |=> out_item_valid && $stable(out_byte)
      && $stable(out_last) && $stable(out_total))
    else $error("stalled result changed");

  // No new item may be taken while a result is stuck at the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_item_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // A result without an encoded byte only marks the end of a block.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_valid |-> out_last && (out_byte == 8'h00))
    else $error("empty result without block end");

  // The total is reported only on the last result of a block.
  a_total_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_last |-> (out_total == '0))
    else $error("total shown before block end");

endmodule

bind run_length_byte_encoder_unit rlbe_checker u_rlbe_checker (.*);

`default_nettype wire

// ===== tb/run_length_byte_encoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_byte_encoder_unit_test
// Feeds byte blocks into the run-length encoder under several block lengths
// and handshake idling patterns. An internal encoder model predicts every
// encoded byte, end mark and total, and each result item is checked in order.
// ----------------------------------------------------------------------------

module run_length_byte_encoder_unit_test;
  import rlbe_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct {
    byte_t            code;
    logic             code_valid;
    logic             code_last;
    logic [LEN_W-1:0] total;
  } code_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  byte_t            in_byte = '0;
  logic             out_item_valid;
  logic             out_item_ready = 1'b0;
  byte_t            out_byte;
  logic             out_valid;
  logic             out_last;
  logic [LEN_W-1:0] out_total;

  // Encoder model state.
  logic [LEN_W-1:0] length_reg = BLOCK_LENGTH_RST;
  byte_t            run_val;
  byte_t            run_len;
  int unsigned      taken;
  int unsigned      emitted;
  bit               full;
  code_item_t       step_codes[$];
  code_item_t       due_codes[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;
  code_item_t got_code;

  run_length_byte_encoder_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_item_valid (out_item_valid),
    .out_item_ready (out_item_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .out_total      (out_total)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void clear_block();
    run_val = '0;
    run_len = '0;
    taken   = 0;
    emitted = 0;
    full    = 1'b0;
  endfunction

  function automatic void emit_byte(input byte_t b);
    if (step_codes.size() < RES_SLOTS) begin
      step_codes.push_back('{code: b, code_valid: 1'b1, code_last: 1'b0, total: '0});
      emitted++;
    end
  endfunction

  function automatic void close_run();
    if (run_len > SHORT_RUN) begin
      emit_byte(ESC_MARK);
      emit_byte(run_len);
      emit_byte(run_val);
    end else begin
      for (int i = 0; i < run_len; i++) emit_byte(run_val);
    end
    run_len = '0;
  endfunction

  // Works out the encoded bytes that one accepted input byte causes.
  function automatic void encode_byte(input byte_t b);
    logic [LEN_W-1:0] eff;
    logic             final_byte;
    int               tail;
    eff = length_reg;
    if (eff == '0) eff = LEN_W'(1);
    if (eff > MAX_LEN) eff = MAX_LEN;
    final_byte = (taken + 1 >= eff);
    step_codes.delete();
    if (!full) begin
      if (run_len != '0 && b == run_val && run_len < RUN_CAP) begin
        run_len++;
      end else begin
        close_run();
        if (emitted < eff - 1) begin
          run_val = b;
          run_len = 8'd1;
        end else begin
          full = 1'b1;
        end
      end
    end
    taken++;
    if (final_byte) begin
      close_run();
      if (step_codes.size() == 0) begin
        step_codes.push_back('{code: '0, code_valid: 1'b0, code_last: 1'b1,
                               total: LEN_W'(emitted)});
      end else begin
        tail = step_codes.size() - 1;
        step_codes[tail].code_last = 1'b1;
        step_codes[tail].total = LEN_W'(emitted);
      end
      clear_block();
    end
    foreach (step_codes[i]) due_codes.push_back(step_codes[i]);
  endfunction

  task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_item_valid && out_item_ready) begin
      if (due_codes.size() == 0) begin
        mismatches++;
        $display({"%0t ns: unexpected result: expected none, ",
                  "actual byte %0h valid %b last %b total %0h"},
                 $time, out_byte, out_valid, out_last, out_total);
      end else begin
        got_code = due_codes.pop_front();
        check_field("out_byte", LEN_W'(got_code.code), LEN_W'(out_byte));
        check_field("out_valid", LEN_W'(got_code.code_valid), LEN_W'(out_valid));
        check_field("out_last", LEN_W'(got_code.code_last), LEN_W'(out_last));
        check_field("out_total", got_code.total, out_total);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_item_ready <= 1'b0;
    end else begin
      out_item_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[run_length_byte_encoder_unit] ERROR");
      $finish;
    end
  end

  // Valid stays high between back-to-back items; it drops for idle cycles and while draining.
  task automatic send_item(input byte_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_reg = value;
  endtask

  // A block left open at the reset length is closed by shrinking the length.
  task automatic test_reset_length();
    send_item(8'h80);
    send_item(8'h80);
    send_item(8'h7F);
    write_length(LEN_W'(2));
    send_item(8'h7F);
  endtask

  task automatic test_short_blocks();
    write_length(LEN_W'(1));
    send_item(8'h00);
    write_length(LEN_W'(0));
    send_item(8'hFF);
    write_length(LEN_W'(3));
    repeat (3) send_item(8'hFF);
    // A run of four closed by a new byte on the final item gives four results.
    write_length(LEN_W'(5));
    repeat (4) send_item(8'h07);
    send_item(8'h08);
    // The second byte cannot open a run, so it is dropped.
    write_length(LEN_W'(2));
    send_item(8'h00);
    send_item(8'hFF);
  endtask

  task automatic test_length_extremes();
    write_length(MAX_LEN);
    send_item(8'h00);
    send_item(8'h01);
    write_length('1);
    send_item(8'hFE);
    send_item(8'hFE);
    write_length(LEN_W'(1));
    send_item(8'hFE);
  endtask

  task automatic test_run_cap();
    write_length(LEN_W'(260));
    repeat (260) send_item(8'h33);
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_length(LEN_W'(20));
    hold_request = 150;
    repeat (20) send_item(byte_t'($urandom_range(255)));
    // Sender pauses here until every result of the first block is out.
    wait_drained();
    repeat (20) send_item(byte_t'($urandom_range(255)));
  endtask

  task automatic test_random_blocks(input int idle_pct, input int stall_pct, input int budget);
    int    sent;
    int    len;
    int    left;
    int    run_n;
    byte_t val;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(15))
        0:       len = 0;
        default: len = $urandom_range(12, 1);
      endcase
      // The last block of the phase is cut to what remains of the budget.
      if (len > budget - sent) len = budget - sent;
      write_length(LEN_W'(len));
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      left = (len == 0) ? 1 : len;
      while (left > 0) begin
        case ($urandom_range(7))
          0:       val = 8'hFF;
          1:       val = 8'h00;
          default: val = byte_t'($urandom_range(255));
        endcase
        if ($urandom_range(9) == 0) run_n = 1;
        else if ($urandom_range(19) == 0) run_n = $urandom_range(270, 100);
        else run_n = $urandom_range(6, 1);
        for (int k = 0; k < run_n && left > 0; k++) begin
          send_item(val);
          left--;
          sent++;
        end
      end
    end
  endtask

  initial begin
    clear_block();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_length();
    test_short_blocks();
    test_length_extremes();
    test_run_cap();
    test_backpressure();
    test_random_blocks(0, 0, 12);
    test_random_blocks(49, 0, 12);
    test_random_blocks(0, 49, 12);
    test_random_blocks(25, 25, 12);
    wait_drained();
    if (mismatches == 0) begin
      $display("[run_length_byte_encoder_unit] OK");
    end else begin
      $display("[run_length_byte_encoder_unit] ERROR");
    end
    $finish;
  end

endmodule
